>>> design/orl_pkg.sv
package orl_pkg;

	localparam int LIST_CAP   = 16;
	localparam int IDX_W      = (LIST_CAP > 1) ? $clog2(LIST_CAP) : 1;
	localparam int CNT_W      = $clog2(LIST_CAP + 1);
	localparam int POS_W      = 5;
	localparam int CMP_W      = (POS_W > CNT_W) ? POS_W : CNT_W;
	localparam int PLATE_B    = 7;
	localparam int TEXT_B     = 19;
	localparam int TEXT_W     = TEXT_B * 8;
	localparam int PAD_W      = TEXT_W - PLATE_B * 8;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFS   = 8'h20;

	typedef logic [TEXT_W-1:0] text_t;

	typedef enum logic [2:0] {
		REQ_APPEND = 3'd0,
		REQ_INSERT = 3'd1,
		REQ_REMOVE = 3'd2,
		REQ_SEARCH = 3'd3,
		REQ_READ   = 3'd4
	} req_e;

	typedef enum logic [1:0] {
		KEY_PLATE = 2'd0,
		KEY_BRAND = 2'd1,
		KEY_MODEL = 2'd2
	} key_e;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE
	} cell_op_e;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_e;

	typedef struct packed {
		logic [55:0] plate;
		logic [63:0] brand_hi;
		logic [63:0] brand_mid;
		logic [23:0] brand_lo;
		logic [63:0] model_hi;
		logic [63:0] model_mid;
		logic [23:0] model_lo;
	} rec_t;

	typedef struct packed {
		logic [2:0]       req_type;
		logic [POS_W-1:0] position;
		logic [1:0]       search_field;
		logic [55:0]      plate;
		logic [63:0]      brand_hi;
		logic [63:0]      brand_mid;
		logic [23:0]      brand_lo;
		logic [63:0]      model_hi;
		logic [63:0]      model_mid;
		logic [23:0]      model_lo;
	} req_t;

	typedef struct packed {
		logic             ok;
		logic [4:0]       entry_count;
		logic [55:0]      out_plate;
		logic [63:0]      out_brand_hi;
		logic [63:0]      out_brand_mid;
		logic [23:0]      out_brand_lo;
		logic [63:0]      out_model_hi;
		logic [63:0]      out_model_mid;
		logic [23:0]      out_model_lo;
	} rsp_t;

	typedef struct packed {
		cell_op_e         op;
		logic [IDX_W-1:0] pos;
		logic [1:0]       key_sel;
		text_t            key;
		rec_t             rec;
	} cell_cmd_t;

	// pick one text field, plate left-aligned and zero padded
	function automatic text_t field_text(input rec_t r, input logic [1:0] sel);
		text_t t;
		unique case (sel)
			KEY_PLATE: t = {r.plate, {PAD_W{1'b0}}};
			KEY_BRAND: t = {r.brand_hi, r.brand_mid, r.brand_lo};
			default:   t = {r.model_hi, r.model_mid, r.model_lo};
		endcase
		return t;
	endfunction

	// cut at first NUL, fold upper case to lower case
	function automatic text_t normalize(input text_t t);
		text_t o;
		logic ended;
		logic [7:0] c;
		ended = 1'b0;
		for (int k = 0; k < TEXT_B; k++) begin
			c = t[TEXT_W-1-8*k -: 8];
			if (ended || c == 8'h00) begin
				ended = 1'b1;
				c = 8'h00;
			end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
				c = c + CASE_OFS;
			end
			o[TEXT_W-1-8*k -: 8] = c;
		end
		return o;
	endfunction

	function automatic rec_t to_rec(input req_t q);
		rec_t r;
		r.plate     = q.plate;
		r.brand_hi  = q.brand_hi;
		r.brand_mid = q.brand_mid;
		r.brand_lo  = q.brand_lo;
		r.model_hi  = q.model_hi;
		r.model_mid = q.model_mid;
		r.model_lo  = q.model_lo;
		return r;
	endfunction

endpackage

>>> design/orl_cell.sv
module orl_cell (
	input  logic                     clk,
	input  logic [orl_pkg::IDX_W-1:0] idx,
	input  orl_pkg::cell_cmd_t       cmd,
	input  orl_pkg::rec_t            left,
	input  orl_pkg::rec_t            right,
	output orl_pkg::rec_t            rec,
	output logic                     match
);
	import orl_pkg::*;

	rec_t rec_q;

	// take the new record, the lower neighbour's or the upper neighbour's, or keep its own
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CELL_INSERT: begin
				if (idx == cmd.pos)
					rec_q <= cmd.rec;
				else if (idx > cmd.pos)
					rec_q <= left;
			end
			CELL_REMOVE: begin
				if (idx >= cmd.pos)
					rec_q <= right;
			end
			default: ;
		endcase
	end

	assign rec   = rec_q;
	assign match = (normalize(field_text(rec_q, cmd.key_sel)) == cmd.key);

endmodule

>>> design/orl_ctrl.sv
module orl_ctrl (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	input  orl_pkg::req_t                             req,
	output logic                                      busy,
	output logic                                      done,
	output orl_pkg::rsp_t                             rsp,
	output orl_pkg::cell_cmd_t                        cmd,
	input  orl_pkg::rec_t [orl_pkg::LIST_CAP-1:0]     cells,
	input  logic [orl_pkg::LIST_CAP-1:0]              match
);
	import orl_pkg::*;

	state_e           state_q, state_d;
	req_t             req_q;
	logic [CNT_W-1:0] count_q, count_d;
	logic             done_q;
	rsp_t             rsp_q, rsp_d;
	logic [CMP_W-1:0] pos_x, cnt_x;
	logic             not_full, pos_le, pos_lt;
	logic [LIST_CAP-1:0] held;
	rec_t             rd_rec;

	assign pos_x    = CMP_W'(req_q.position);
	assign cnt_x    = CMP_W'(count_q);
	assign not_full = (count_q < CNT_W'(LIST_CAP));
	assign pos_le   = (pos_x <= cnt_x);
	assign pos_lt   = (pos_x < cnt_x);

	always_comb begin
		for (int i = 0; i < LIST_CAP; i++)
			held[i] = (CNT_W'(i) < count_q);
	end

	assign rd_rec = cells[req_q.position[IDX_W-1:0]];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_EXEC;
			ST_EXEC: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy        = (state_q == ST_EXEC);
		cmd.op      = CELL_HOLD;
		cmd.pos     = req_q.position[IDX_W-1:0];
		cmd.key_sel = req_q.search_field;
		cmd.key     = normalize(field_text(to_rec(req_q), req_q.search_field));
		cmd.rec     = to_rec(req_q);
		count_d     = count_q;
		rsp_d       = '0;
		if (state_q == ST_EXEC) begin
			unique case (req_q.req_type)
				REQ_APPEND: begin
					if (not_full) begin
						cmd.op    = CELL_INSERT;
						cmd.pos   = count_q[IDX_W-1:0];
						count_d   = count_q + 1'b1;
						rsp_d.ok  = 1'b1;
					end
				end
				REQ_INSERT: begin
					if (not_full && pos_le) begin
						cmd.op    = CELL_INSERT;
						count_d   = count_q + 1'b1;
						rsp_d.ok  = 1'b1;
					end
				end
				REQ_REMOVE: begin
					if (pos_lt) begin
						cmd.op    = CELL_REMOVE;
						count_d   = count_q - 1'b1;
						rsp_d.ok  = 1'b1;
					end
				end
				REQ_SEARCH: rsp_d.ok = |(match & held);
				REQ_READ: begin
					if (pos_lt) begin
						rsp_d.ok            = 1'b1;
						rsp_d.out_plate     = rd_rec.plate;
						rsp_d.out_brand_hi  = rd_rec.brand_hi;
						rsp_d.out_brand_mid = rd_rec.brand_mid;
						rsp_d.out_brand_lo  = rd_rec.brand_lo;
						rsp_d.out_model_hi  = rd_rec.model_hi;
						rsp_d.out_model_mid = rd_rec.model_mid;
						rsp_d.out_model_lo  = rd_rec.model_lo;
					end
				end
				default: ;
			endcase
		end
		rsp_d.entry_count = 5'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= (state_q == ST_EXEC);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start)
			req_q <= req;
		if (state_q == ST_EXEC)
			rsp_q <= rsp_d;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

>>> design/ordered_record_list_unit.sv
// Ordered record list: up to LIST_CAP records of plate, brand and model text.
// Request channel: drive req and raise start; the transaction is taken on the
// rising edge where start is high and busy is low. req_type selects append,
// insert at position, remove at position, case-insensitive search on the
// field named by search_field, or read by position.
// Response channel: done is high for exactly one cycle with rsp valid in the
// same cycle. The receiver has no way to stall, so capture rsp when done rises.
// busy is high while the transaction executes, and done rises as busy falls;
// a new transaction can be taken in the cycle where done is high. Each
// transaction passes the request register, then the cell row, where every cell
// shifts or compares in the same cycle, then the response register.
// Reset (arst_n low) empties the list and returns the unit to idle; record
// storage is not cleared, as slots at or above the count are never read.
module ordered_record_list_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  orl_pkg::req_t  req,
	output logic           busy,
	output logic           done,
	output orl_pkg::rsp_t  rsp
);
	import orl_pkg::*;

	cell_cmd_t             cmd;
	rec_t [LIST_CAP-1:0]   cells;
	logic [LIST_CAP-1:0]   match;

	// sequencer: latch the transaction, drive the row, gather the answer
	orl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp),
		.cmd    (cmd),
		.cells  (cells),
		.match  (match)
	);

	// row of cells; each sees its neighbours, the ends see themselves
	for (genvar i = 0; i < LIST_CAP; i++) begin : g_cell
		orl_cell u_cell (
			.clk   (clk),
			.idx   (IDX_W'(i)),
			.cmd   (cmd),
			.left  (cells[(i == 0) ? i : i - 1]),
			.right (cells[(i == LIST_CAP - 1) ? i : i + 1]),
			.rec   (cells[i]),
			.match (match[i])
		);
	end

endmodule
